@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL.
// Compiled to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

@@ rtl/core/msc_pkg.sv @@
// Types, opcodes and constants of the MIPS subset core.
// No dependencies; used by msc_decode, msc_regfile and the top level.
`timescale 1ns / 1ps

package msc_pkg;

   typedef enum logic [2:0] {
      CLS_NOP   = 3'd0,
      CLS_R     = 3'd1,
      CLS_I     = 3'd2,
      CLS_J     = 3'd3,
      CLS_UNSUP = 3'd4
   } inst_class_type;

   typedef enum logic [2:0] {
      PC_SEQ,
      PC_JR,
      PC_BEQ,
      PC_BNE,
      PC_JUMP
   } pc_sel_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_ADD,
      WB_ADDI,
      WB_SLT,
      WB_LOAD,
      WB_LINK
   } wb_sel_type;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_NOP  = 6'd0;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_MOVE = 6'd37;

   localparam logic [4:0] RF_ZERO = 5'd0;
   localparam logic [4:0] RF_SP   = 5'd29;
   localparam logic [4:0] RF_RA   = 5'd31;

   localparam logic [31:0] SP_RESET = 32'd16777216;
   localparam logic [31:0] RA_RESET = 32'hFFFF_FFFF;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_START     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_SENTINEL = 8'd1;

   typedef struct packed {
      inst_class_type cls;
      pc_sel_type     pc_sel;
      wb_sel_type     wb_sel;
      logic [4:0]     wb_reg;
      logic           store;
   } dec_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

   function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
      case (idx)
         RF_SP:   return SP_RESET;
         RF_RA:   return RA_RESET;
         default: return 32'd0;
      endcase
   endfunction

endpackage

@@ rtl/core/msc_decode.sv @@
// Instruction decoder: class, next-PC select, write-back select and target.
// Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_decode (
   input  logic [31:0]      instr,
   output msc_pkg::dec_type dec
);

   logic [5:0] op;
   logic [5:0] fn;

   assign op = instr[31:26];
   assign fn = instr[5:0];

   always_comb begin
      dec = '{cls: msc_pkg::CLS_UNSUP, pc_sel: msc_pkg::PC_SEQ, wb_sel: msc_pkg::WB_NONE,
              wb_reg: msc_pkg::RF_ZERO, store: 1'b0};
      unique case (op) inside
         msc_pkg::OP_SPECIAL: begin
            unique case (fn) inside
               msc_pkg::FN_NOP: begin
                  dec.cls = msc_pkg::CLS_NOP;
               end
               msc_pkg::FN_ADDU, msc_pkg::FN_MOVE: begin
                  dec.cls    = msc_pkg::CLS_R;
                  dec.wb_sel = msc_pkg::WB_ADD;
                  dec.wb_reg = instr[15:11];
               end
               msc_pkg::FN_JR: begin
                  dec.cls    = msc_pkg::CLS_R;
                  dec.pc_sel = msc_pkg::PC_JR;
               end
               default: ;
            endcase
         end
         msc_pkg::OP_J: begin
            dec.cls    = msc_pkg::CLS_J;
            dec.pc_sel = msc_pkg::PC_JUMP;
         end
         msc_pkg::OP_JAL: begin
            dec.cls    = msc_pkg::CLS_J;
            dec.pc_sel = msc_pkg::PC_JUMP;
            dec.wb_sel = msc_pkg::WB_LINK;
            dec.wb_reg = msc_pkg::RF_RA;
         end
         msc_pkg::OP_ADDIU: begin
            dec.cls    = msc_pkg::CLS_I;
            dec.wb_sel = msc_pkg::WB_ADDI;
            dec.wb_reg = instr[20:16];
         end
         msc_pkg::OP_SLTI: begin
            dec.cls    = msc_pkg::CLS_I;
            dec.wb_sel = msc_pkg::WB_SLT;
            dec.wb_reg = instr[20:16];
         end
         msc_pkg::OP_LW: begin
            dec.cls    = msc_pkg::CLS_I;
            dec.wb_sel = msc_pkg::WB_LOAD;
            dec.wb_reg = instr[20:16];
         end
         msc_pkg::OP_SW: begin
            dec.cls   = msc_pkg::CLS_I;
            dec.store = 1'b1;
         end
         msc_pkg::OP_BEQ: begin
            dec.cls    = msc_pkg::CLS_I;
            dec.pc_sel = msc_pkg::PC_BEQ;
         end
         msc_pkg::OP_BNE: begin
            dec.cls    = msc_pkg::CLS_I;
            dec.pc_sel = msc_pkg::PC_BNE;
         end
         default: ;
      endcase
      // $zero is never written
      if (dec.wb_reg == msc_pkg::RF_ZERO) begin
         dec.wb_sel = msc_pkg::WB_NONE;
      end
   end

endmodule

@@ rtl/core/msc_regfile.sv @@
// 32 x 32 register file: one write port, two registered read ports.
// Per-entry valid bits give the reset contents. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_regfile (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [4:0]         rd_addr_a,
   input  logic [4:0]         rd_addr_b,
   output logic [31:0]        rd_data_a,
   output logic [31:0]        rd_data_b,
   input  msc_pkg::rf_wr_type wr
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : msc_pkg::rf_reset_value(rd_addr_a);
         rd_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : msc_pkg::rf_reset_value(rd_addr_b);
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/mips_subset_single_cycle_core_unit.sv @@
// Top level of the MIPS subset core: operand stage, commit stage, response register.
// Depends on msc_pkg, msc_decode, msc_regfile and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_instr
//   rsp     | out       | rsp_valid/rsp_stall | rsp_next_pc ... rsp_j_count
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One instruction per cycle while req_stall is low; a taken request passes through the operand stage, the commit
// stage and the response register. Pipeline: register read at accept, operand/address stage with data memory port,
// commit stage. Operands are forwarded from the commit stage and from the last committed write.
// After reset the data memory is zeroed word by word with req_stall high until the clear is done.
// rsp_stall freezes the whole pipeline; DMEM_WORDS must be a power of two.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_subset_single_cycle_core_unit #(
   parameter int DMEM_WORDS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [31:0]                   req_instr,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [31:0]                   rsp_next_pc,
   output logic                          rsp_halted,
   output logic [2:0]                    rsp_inst_class,
   output logic                          rsp_wb_valid,
   output logic [4:0]                    rsp_wb_reg,
   output logic [31:0]                   rsp_wb_value,
   output logic                          rsp_store_valid,
   output logic [9:0]                    rsp_store_addr,
   output logic [31:0]                   rsp_cycle_count,
   output logic [31:0]                   rsp_r_count,
   output logic [31:0]                   rsp_i_count,
   output logic [31:0]                   rsp_j_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int DMEM_AW = $clog2(DMEM_WORDS);
   localparam logic [DMEM_AW-1:0] DMEM_LAST = DMEM_AW'(DMEM_WORDS - 1);

   // handshake
   logic adv;
   logic accept;
   logic csr_wr;

   // memory clear
   logic               clr_busy_ff;
   logic [DMEM_AW-1:0] clr_idx_ff;

   // operand stage
   logic               s0_valid_ff;
   logic [31:0]        s0_instr_ff;
   msc_pkg::dec_type   s0_dec;
   logic [31:0]        rf_a_q;
   logic [31:0]        rf_b_q;
   logic [4:0]         s0_rs;
   logic [4:0]         s0_rt;
   logic [31:0]        op_a;
   logic [31:0]        op_b;
   logic [31:0]        imm;
   logic [31:0]        mem_addr;
   logic [DMEM_AW-1:0] s0_idx;
   logic [31:0]        alu;

   // commit stage
   logic               s1_valid_ff;
   msc_pkg::dec_type   s1_dec_ff;
   logic [31:0]        s1_alu_ff;
   logic [31:0]        s1_a_ff;
   logic               s1_eq_ff;
   logic [31:0]        s1_off_ff;
   logic [25:0]        s1_jidx_ff;
   logic [DMEM_AW-1:0] s1_idx_ff;
   logic [31:0]        s1_idx_ext;
   logic [31:0]        dmem_q_ff;
   logic               s1_wr;
   logic               s1_live;
   logic [31:0]        s1_wval;
   logic [31:0]        seq;
   logic [31:0]        tgt;
   logic [31:0]        npc;

   logic [31:0] dmem [DMEM_WORDS];

   // architectural state
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;
   logic [31:0] cyc_cnt_ff, cyc_cnt_in;
   logic [31:0] r_cnt_ff, r_cnt_in;
   logic [31:0] i_cnt_ff, i_cnt_in;
   logic [31:0] j_cnt_ff, j_cnt_in;
   logic [31:0] sentinel_ff;

   // last committed register write
   logic        lc_valid_ff;
   logic [4:0]  lc_reg_ff;
   logic [31:0] lc_value_ff;

   msc_pkg::rf_wr_type rf_wr;
   logic               rf_commit;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_next_pc_ff;
   logic        rsp_halted_ff;
   logic [2:0]  rsp_inst_class_ff;
   logic        rsp_wb_valid_ff;
   logic [4:0]  rsp_wb_reg_ff;
   logic [31:0] rsp_wb_value_ff;
   logic        rsp_store_valid_ff;
   logic [9:0]  rsp_store_addr_ff;
   logic [31:0] rsp_cycle_count_ff;
   logic [31:0] rsp_r_count_ff;
   logic [31:0] rsp_i_count_ff;
   logic [31:0] rsp_j_count_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || clr_busy_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // ---------------------------------------------------------------- memory clear
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == DMEM_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- operand stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_instr_ff <= req_instr;
      end
   end

   msc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (adv),
      .rd_addr_a (req_instr[25:21]),
      .rd_addr_b (req_instr[20:16]),
      .rd_data_a (rf_a_q),
      .rd_data_b (rf_b_q),
      .wr        (rf_wr)
   );

   msc_decode u_decode (
      .instr (s0_instr_ff),
      .dec   (s0_dec)
   );

   assign s0_rs = s0_instr_ff[25:21];
   assign s0_rt = s0_instr_ff[20:16];
   assign imm   = {{16{s0_instr_ff[15]}}, s0_instr_ff[15:0]};

   always_comb begin
      if (s1_valid_ff && s1_wr && s1_dec_ff.wb_reg == s0_rs) begin
         op_a = s1_wval;
      end else if (lc_valid_ff && lc_reg_ff == s0_rs) begin
         op_a = lc_value_ff;
      end else begin
         op_a = rf_a_q;
      end
      if (s1_valid_ff && s1_wr && s1_dec_ff.wb_reg == s0_rt) begin
         op_b = s1_wval;
      end else if (lc_valid_ff && lc_reg_ff == s0_rt) begin
         op_b = lc_value_ff;
      end else begin
         op_b = rf_b_q;
      end
   end

   assign mem_addr = op_a + imm;
   assign s0_idx   = mem_addr[DMEM_AW-1:0];

   always_comb begin
      case (s0_dec.wb_sel)
         msc_pkg::WB_ADD: alu = op_a + op_b;
         msc_pkg::WB_SLT: alu = {31'd0, $signed(op_a) < $signed(imm)};
         default:         alu = mem_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_idx_ff] <= '0;
      end else if (adv && s0_valid_ff && s0_dec.store) begin
         dmem[s0_idx] <= op_b;
      end
      if (adv) begin
         dmem_q_ff <= dmem[s0_idx];
      end
   end

   // ---------------------------------------------------------------- commit stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dec_ff  <= s0_dec;
         s1_alu_ff  <= alu;
         s1_a_ff    <= op_a;
         s1_eq_ff   <= (op_a == op_b);
         s1_off_ff  <= {imm[29:0], 2'b00} + 32'd4;
         s1_jidx_ff <= s0_instr_ff[25:0];
         s1_idx_ff  <= s0_idx;
      end
   end

   assign s1_wr      = (s1_dec_ff.wb_sel != msc_pkg::WB_NONE);
   assign s1_live    = s1_valid_ff && !halt_ff;
   assign s1_idx_ext = 32'(s1_idx_ff);
   assign seq        = pc_ff + 32'd4;
   assign tgt        = pc_ff + s1_off_ff;

   always_comb begin
      case (s1_dec_ff.wb_sel)
         msc_pkg::WB_LOAD: s1_wval = dmem_q_ff;
         msc_pkg::WB_LINK: s1_wval = seq;
         default:          s1_wval = s1_alu_ff;
      endcase
   end

   always_comb begin
      case (s1_dec_ff.pc_sel)
         msc_pkg::PC_JR:   npc = s1_a_ff;
         msc_pkg::PC_BEQ:  npc = s1_eq_ff ? tgt : seq;
         msc_pkg::PC_BNE:  npc = s1_eq_ff ? seq : tgt;
         msc_pkg::PC_JUMP: npc = {seq[31:28], s1_jidx_ff, 2'b00};
         default:          npc = seq;
      endcase
   end

   always_comb begin
      pc_in      = pc_ff;
      halt_in    = halt_ff;
      cyc_cnt_in = cyc_cnt_ff;
      r_cnt_in   = r_cnt_ff;
      i_cnt_in   = i_cnt_ff;
      j_cnt_in   = j_cnt_ff;
      if (s1_live) begin
         pc_in      = npc;
         halt_in    = (npc == sentinel_ff);
         cyc_cnt_in = cyc_cnt_ff + 32'd1;
         case (s1_dec_ff.cls)
            msc_pkg::CLS_R: r_cnt_in = r_cnt_ff + 32'd1;
            msc_pkg::CLS_I: i_cnt_in = i_cnt_ff + 32'd1;
            msc_pkg::CLS_J: j_cnt_in = j_cnt_ff + 32'd1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         halt_ff    <= 1'b0;
         cyc_cnt_ff <= '0;
         r_cnt_ff   <= '0;
         i_cnt_ff   <= '0;
         j_cnt_ff   <= '0;
      end else if (adv) begin
         pc_ff      <= pc_in;
         halt_ff    <= halt_in;
         cyc_cnt_ff <= cyc_cnt_in;
         r_cnt_ff   <= r_cnt_in;
         i_cnt_ff   <= i_cnt_in;
         j_cnt_ff   <= j_cnt_in;
      end
   end

   // register file write port: csr loads of sp/ra, else commit
   assign rf_commit = adv && s1_live && s1_wr;

   always_comb begin
      rf_wr = '{en: rf_commit, addr: s1_dec_ff.wb_reg, data: s1_wval};
      if (csr_wr && csr_index == msc_pkg::CSR_STACK_START) begin
         rf_wr = '{en: 1'b1, addr: msc_pkg::RF_SP, data: csr_wdata};
      end else if (csr_wr && csr_index == msc_pkg::CSR_RETURN_SENTINEL) begin
         rf_wr = '{en: 1'b1, addr: msc_pkg::RF_RA, data: csr_wdata};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sentinel_ff <= msc_pkg::RA_RESET;
      end else if (csr_wr && csr_index == msc_pkg::CSR_RETURN_SENTINEL) begin
         sentinel_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_valid_ff <= 1'b0;
      end else if (csr_wr) begin
         lc_valid_ff <= 1'b0;
      end else if (adv) begin
         lc_valid_ff <= rf_commit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lc_reg_ff   <= s1_dec_ff.wb_reg;
         lc_value_ff <= s1_wval;
      end
   end

   // ---------------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         rsp_next_pc_ff     <= pc_in;
         rsp_halted_ff      <= halt_in;
         rsp_cycle_count_ff <= cyc_cnt_in;
         rsp_r_count_ff     <= r_cnt_in;
         rsp_i_count_ff     <= i_cnt_in;
         rsp_j_count_ff     <= j_cnt_in;
         if (halt_ff) begin
            rsp_inst_class_ff  <= msc_pkg::CLS_NOP;
            rsp_wb_valid_ff    <= 1'b0;
            rsp_wb_reg_ff      <= '0;
            rsp_wb_value_ff    <= '0;
            rsp_store_valid_ff <= 1'b0;
            rsp_store_addr_ff  <= '0;
         end else begin
            rsp_inst_class_ff  <= s1_dec_ff.cls;
            rsp_wb_valid_ff    <= s1_wr;
            rsp_wb_reg_ff      <= s1_wr ? s1_dec_ff.wb_reg : 5'd0;
            rsp_wb_value_ff    <= s1_wr ? s1_wval : 32'd0;
            rsp_store_valid_ff <= s1_dec_ff.store;
            rsp_store_addr_ff  <= s1_dec_ff.store ? s1_idx_ext[9:0] : 10'd0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_inst_class  = rsp_inst_class_ff;
   assign rsp_wb_valid    = rsp_wb_valid_ff;
   assign rsp_wb_reg      = rsp_wb_reg_ff;
   assign rsp_wb_value    = rsp_wb_value_ff;
   assign rsp_store_valid = rsp_store_valid_ff;
   assign rsp_store_addr  = rsp_store_addr_ff;
   assign rsp_cycle_count = rsp_cycle_count_ff;
   assign rsp_r_count     = rsp_r_count_ff;
   assign rsp_i_count     = rsp_i_count_ff;
   assign rsp_j_count     = rsp_j_count_ff;

   // ---------------------------------------------------------------- assertions
   `ASSERT_CLK(a_halt_holds, clock, reset, halt_ff |=> (halt_ff && $stable(pc_ff)), "halted core moved its pc")
   `ASSERT_CLK(a_rf_no_zero, clock, reset, rf_wr.en |-> (rf_wr.addr != msc_pkg::RF_ZERO), "write to register zero")
   `ASSERT_NEVER(a_no_item_clearing, clock, reset, clr_busy_ff && (s0_valid_ff || s1_valid_ff), "request in flight during memory clear")
   `ASSERT_CLK(a_cycle_count, clock, reset, (adv && s1_live) |=> (cyc_cnt_ff == $past(cyc_cnt_ff) + 32'd1), "instruction count did not advance on commit")

endmodule

@@ tb/tb_mips_subset_single_cycle_core_unit.sv @@
// Self-checking testbench for mips_subset_single_cycle_core_unit: a directed instruction table,
// then constrained-by-hand random programs checked against an in-bench instruction predictor.
// Depends on msc_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_mips_subset_single_cycle_core_unit;
   import msc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int DMEM_DEPTH     = 1024;

   typedef struct packed {
      logic [31:0]    next_pc;
      logic           halted;
      inst_class_type cls;
      logic           wb_valid;
      logic [4:0]     wb_reg;
      logic [31:0]    wb_value;
      logic           store_valid;
      logic [9:0]     store_addr;
      logic [31:0]    cycle_count;
      logic [31:0]    r_count;
      logic [31:0]    i_count;
      logic [31:0]    j_count;
   } core_rsp_t;

   typedef struct {
      logic [31:0] instr;
      bit          lit;
      core_rsp_t   want;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instr = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_halted;
   logic [2:0]  rsp_inst_class;
   logic        rsp_wb_valid;
   logic [4:0]  rsp_wb_reg;
   logic [31:0] rsp_wb_value;
   logic        rsp_store_valid;
   logic [9:0]  rsp_store_addr;
   logic [31:0] rsp_cycle_count;
   logic [31:0] rsp_r_count;
   logic [31:0] rsp_i_count;
   logic [31:0] rsp_j_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor state
   logic [31:0] core_pc;
   logic [31:0] gpr [32];
   logic [31:0] dmem_img [DMEM_DEPTH];
   logic [31:0] retired, r_tally, i_tally, j_tally;
   logic        halt_seen;
   logic [31:0] ret_sentinel;

   core_rsp_t   pending_rsp [$];
   stim_row_t   stim_q [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatches = 0;
   int          n_req = 0;
   int          n_rsp = 0;
   int          class_seen [5];
   int          quiet_cycles = 0;

   mips_subset_single_cycle_core_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_instr       (req_instr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_halted      (rsp_halted),
      .rsp_inst_class  (rsp_inst_class),
      .rsp_wb_valid    (rsp_wb_valid),
      .rsp_wb_reg      (rsp_wb_reg),
      .rsp_wb_value    (rsp_wb_value),
      .rsp_store_valid (rsp_store_valid),
      .rsp_store_addr  (rsp_store_addr),
      .rsp_cycle_count (rsp_cycle_count),
      .rsp_r_count     (rsp_r_count),
      .rsp_i_count     (rsp_i_count),
      .rsp_j_count     (rsp_j_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [5:0] fn);
      return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
   endfunction

   function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
      return {op, tgt};
   endfunction

   // Executes one instruction against the predictor state; commit=0 only peeks.
   function automatic core_rsp_t execute_instr(input logic [31:0] ins, input bit commit);
      core_rsp_t      r;
      logic [5:0]     op, fn;
      logic [4:0]     rs, rt, rd, wreg;
      logic [31:0]    imm, a, b, seq, npc, wval, ea;
      logic [31:0]    cyc, rc, ic, jc;
      logic [9:0]     saddr;
      logic           wr, st;
      inst_class_type cls;
      r = '0;
      if (halt_seen) begin
         r.next_pc     = core_pc;
         r.halted      = 1'b1;
         r.cls         = CLS_NOP;
         r.cycle_count = retired;
         r.r_count     = r_tally;
         r.i_count     = i_tally;
         r.j_count     = j_tally;
         return r;
      end
      op  = ins[31:26];
      rs  = ins[25:21];
      rt  = ins[20:16];
      rd  = ins[15:11];
      fn  = ins[5:0];
      imm = {{16{ins[15]}}, ins[15:0]};
      a   = gpr[rs];
      b   = gpr[rt];
      ea  = a + imm;
      seq = core_pc + 32'd4;
      npc = seq;
      cls = CLS_UNSUP;
      wr = 1'b0; st = 1'b0; wreg = '0; wval = '0; saddr = '0;
      cyc = retired + 32'd1;
      rc = r_tally; ic = i_tally; jc = j_tally;
      if (op == OP_SPECIAL) begin
         if (fn == FN_NOP) begin
            cls = CLS_NOP;
         end else if (fn == FN_ADDU || fn == FN_MOVE) begin
            cls = CLS_R; wr = 1'b1; wreg = rd; wval = a + b;
         end else if (fn == FN_JR) begin
            cls = CLS_R; npc = a;
         end
      end else if (op == OP_J || op == OP_JAL) begin
         cls = CLS_J;
         npc = {seq[31:28], ins[25:0], 2'b00};
         if (op == OP_JAL) begin
            wr = 1'b1; wreg = RF_RA; wval = seq;
         end
      end else begin
         cls = CLS_I;
         case (op)
            OP_ADDIU: begin
               wr = 1'b1; wreg = rt; wval = ea;
            end
            OP_SLTI: begin
               wr = 1'b1; wreg = rt; wval = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
            end
            OP_LW: begin
               wr = 1'b1; wreg = rt; wval = dmem_img[ea % DMEM_DEPTH];
            end
            OP_SW: begin
               st = 1'b1; saddr = 10'(ea % DMEM_DEPTH);
            end
            OP_BEQ: if (a == b) npc = seq + (imm << 2);
            OP_BNE: if (a != b) npc = seq + (imm << 2);
            default: cls = CLS_UNSUP;
         endcase
      end
      case (cls)
         CLS_R: rc = rc + 32'd1;
         CLS_I: ic = ic + 32'd1;
         CLS_J: jc = jc + 32'd1;
         default: ;
      endcase
      if (wr && wreg == RF_ZERO) wr = 1'b0;
      if (!wr) begin
         wreg = '0; wval = '0;
      end
      if (commit) begin
         if (wr) gpr[wreg] = wval;
         if (st) dmem_img[saddr] = b;
         core_pc   = npc;
         retired   = cyc;
         r_tally   = rc;
         i_tally   = ic;
         j_tally   = jc;
         halt_seen = (npc == ret_sentinel);
      end
      r.next_pc     = npc;
      r.halted      = (npc == ret_sentinel);
      r.cls         = cls;
      r.wb_valid    = wr;
      r.wb_reg      = wreg;
      r.wb_value    = wval;
      r.store_valid = st;
      r.store_addr  = saddr;
      r.cycle_count = cyc;
      r.r_count     = rc;
      r.i_count     = ic;
      r.j_count     = jc;
      return r;
   endfunction

   function automatic logic [4:0] pick_reg();
      logic [4:0] r;
      if ($urandom_range(0, 9) < 7) r = 5'($urandom_range(0, 7));
      else r = 5'($urandom_range(0, 31));
      return r;
   endfunction

   function automatic logic [31:0] rand_instr();
      logic [4:0]  rs, rt, rd;
      logic [15:0] imm, near;
      rs   = pick_reg();
      rt   = pick_reg();
      rd   = pick_reg();
      imm  = 16'($urandom);
      near = 16'(int'($urandom_range(0, 63)) - 32);
      case ($urandom_range(0, 15))
         0:       return enc_r(rs, rt, rd, FN_NOP);
         1:       return enc_r(rs, rt, rd, FN_ADDU);
         2:       return enc_r(rs, rt, rd, FN_MOVE);
         3:       return enc_r(rs, rt, rd, FN_JR);
         4, 5:    return enc_i(OP_ADDIU, rs, rt, $urandom_range(0, 1) ? imm : near);
         6:       return enc_i(OP_SLTI, rs, rt, $urandom_range(0, 1) ? imm : near);
         7, 8:    return enc_i(OP_LW, $urandom_range(0, 1) ? RF_ZERO : rs, rt,
                               $urandom_range(0, 3) == 0 ? imm : near);
         9, 10:   return enc_i(OP_SW, $urandom_range(0, 1) ? RF_ZERO : rs, rt,
                               $urandom_range(0, 3) == 0 ? imm : near);
         11:      return enc_i(OP_BEQ, rs, $urandom_range(0, 1) ? rs : rt,
                               $urandom_range(0, 1) ? imm : near);
         12:      return enc_i(OP_BNE, rs, $urandom_range(0, 1) ? rs : rt,
                               $urandom_range(0, 1) ? imm : near);
         13:      return enc_j(OP_J, 26'($urandom));
         14:      return enc_j(OP_JAL, 26'($urandom));
         default: return $urandom_range(0, 1) ? $urandom
                                              : enc_r(rs, rt, rd, 6'($urandom_range(1, 63)));
      endcase
   endfunction

   function automatic stim_row_t row(input logic [31:0] ins);
      stim_row_t s;
      s.instr = ins;
      s.lit   = 1'b0;
      s.want  = '0;
      return s;
   endfunction

   function automatic stim_row_t lit_row(input logic [31:0] ins, input logic [31:0] npc,
                                         input inst_class_type cls, input logic [4:0] wreg,
                                         input logic [31:0] wval, input logic [31:0] cyc,
                                         input logic [31:0] ic);
      stim_row_t s;
      s.instr = ins;
      s.lit   = 1'b1;
      s.want  = '0;
      s.want.next_pc     = npc;
      s.want.cls         = cls;
      s.want.wb_valid    = (wreg != RF_ZERO);
      s.want.wb_reg      = wreg;
      s.want.wb_value    = wval;
      s.want.cycle_count = cyc;
      s.want.i_count     = ic;
      return s;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("ERROR %s: got %h expected %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) note_mismatch(what, got, want);
   endtask

   task automatic check_rsp();
      core_rsp_t got, want;
      got.next_pc     = rsp_next_pc;
      got.halted      = rsp_halted;
      got.cls         = inst_class_type'(rsp_inst_class);
      got.wb_valid    = rsp_wb_valid;
      got.wb_reg      = rsp_wb_reg;
      got.wb_value    = rsp_wb_value;
      got.store_valid = rsp_store_valid;
      got.store_addr  = rsp_store_addr;
      got.cycle_count = rsp_cycle_count;
      got.r_count     = rsp_r_count;
      got.i_count     = rsp_i_count;
      got.j_count     = rsp_j_count;
      if (pending_rsp.size() == 0) begin
         note_mismatch("response with no request pending", got.next_pc, 32'd0);
         return;
      end
      want = pending_rsp.pop_front();
      n_rsp++;
      if (got.cls <= CLS_UNSUP) class_seen[int'(got.cls)]++;
      check_field("next_pc", got.next_pc, want.next_pc);
      check_field("halted", got.halted, want.halted);
      check_field("inst_class", got.cls, want.cls);
      check_field("wb_valid", got.wb_valid, want.wb_valid);
      check_field("wb_reg", got.wb_reg, want.wb_reg);
      check_field("wb_value", got.wb_value, want.wb_value);
      check_field("store_valid", got.store_valid, want.store_valid);
      check_field("store_addr", got.store_addr, want.store_addr);
      check_field("cycle_count", got.cycle_count, want.cycle_count);
      check_field("r_count", got.r_count, want.r_count);
      check_field("i_count", got.i_count, want.i_count);
      check_field("j_count", got.j_count, want.j_count);
   endtask

   // Presents one request; leaves req_valid high so back-to-back requests stay contiguous.
   task automatic send_instr(input logic [31:0] ins, input bit lit, input core_rsp_t lit_rsp);
      core_rsp_t want;
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         req_instr <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instr <= ins;
      do @(posedge clock); while (req_stall);
      want = execute_instr(ins, 1'b1);
      pending_rsp.push_back(lit ? lit_rsp : want);
      n_req++;
   endtask

   task automatic run_random(input int count);
      logic [31:0] ins;
      core_rsp_t   peek;
      repeat (count) begin
         // keep the core running until the final halt
         do begin
            ins  = rand_instr();
            peek = execute_instr(ins, 1'b0);
         end while (peek.halted);
         send_instr(ins, 1'b0, '0);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_csrs(input logic [31:0] sp_val, input logic [31:0] ra_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_STACK_START;
      csr_wdata <= sp_val;
      do @(posedge clock); while (!csr_ready);
      gpr[RF_SP] = sp_val;
      csr_index <= CSR_RETURN_SENTINEL;
      csr_wdata <= ra_val;
      do @(posedge clock); while (!csr_ready);
      ret_sentinel = ra_val;
      gpr[RF_RA]   = ra_val;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(1, 100) <= recv_idle_pct);
         if (rsp_valid && !rsp_stall) check_rsp();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("mips_subset_single_cycle_core_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      int n_directed;
      core_pc      = '0;
      retired      = '0;
      r_tally      = '0;
      i_tally      = '0;
      j_tally      = '0;
      halt_seen    = 1'b0;
      ret_sentinel = RA_RESET;
      for (int k = 0; k < 32; k++) gpr[k] = '0;
      gpr[RF_SP] = SP_RESET;
      gpr[RF_RA] = RA_RESET;
      for (int k = 0; k < DMEM_DEPTH; k++) dmem_img[k] = '0;
      for (int k = 0; k < 5; k++) class_seen[k] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      stim_q.push_back(lit_row(32'h0000_0000, 32'd4, CLS_NOP, RF_ZERO, 32'd0, 32'd1, 32'd0));
      stim_q.push_back(lit_row(enc_i(OP_ADDIU, RF_ZERO, 5'd1, 16'h7FFF), 32'd8, CLS_I,
                               5'd1, 32'h0000_7FFF, 32'd2, 32'd1));
      stim_q.push_back(lit_row(enc_i(OP_ADDIU, RF_ZERO, 5'd2, 16'h8000), 32'd12, CLS_I,
                               5'd2, 32'hFFFF_8000, 32'd3, 32'd2));
      stim_q.push_back(lit_row(32'hFFFF_FFFF, 32'd16, CLS_UNSUP, RF_ZERO, 32'd0, 32'd4,
                               32'd2));
      stim_q.push_back(row(enc_r(5'd1, 5'd2, 5'd3, FN_ADDU)));
      stim_q.push_back(row(enc_r(5'd1, 5'd2, RF_ZERO, FN_ADDU)));
      stim_q.push_back(row(enc_r(RF_SP, RF_ZERO, 5'd4, FN_MOVE)));
      stim_q.push_back(row(enc_i(OP_SLTI, 5'd2, 5'd5, 16'h0000)));
      stim_q.push_back(row(enc_i(OP_SLTI, 5'd1, 5'd6, 16'hFFFF)));
      stim_q.push_back(row(enc_i(OP_SW, RF_ZERO, 5'd1, 16'hFFFF)));
      stim_q.push_back(row(enc_i(OP_SW, RF_SP, 5'd3, 16'h0000)));
      stim_q.push_back(row(enc_i(OP_LW, RF_ZERO, 5'd7, 16'hFFFF)));
      stim_q.push_back(row(enc_i(OP_LW, RF_ZERO, 5'd8, 16'h0000)));
      stim_q.push_back(row(enc_i(OP_LW, RF_ZERO, RF_ZERO, 16'h0000)));
      stim_q.push_back(row(enc_i(OP_BEQ, 5'd1, 5'd1, 16'h0003)));
      stim_q.push_back(row(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h7FFF)));
      stim_q.push_back(row(enc_i(OP_BNE, 5'd1, 5'd2, 16'h8000)));
      stim_q.push_back(row(enc_i(OP_BNE, RF_ZERO, RF_ZERO, 16'h0010)));
      stim_q.push_back(row(enc_j(OP_J, 26'h3FF_FFFF)));
      stim_q.push_back(row(enc_j(OP_JAL, 26'h000_0000)));
      stim_q.push_back(row(enc_r(5'd1, RF_ZERO, RF_ZERO, FN_JR)));
      stim_q.push_back(row(enc_r(5'd1, 5'd2, 5'd3, 6'h3F)));
      stim_q.push_back(row(enc_r(5'd1, 5'd2, RF_ZERO, 6'd24)));
      stim_q.push_back(row(32'h03FF_F7C0));
      n_directed = stim_q.size();

      send_idle_pct = 20;
      recv_idle_pct = 87;
      foreach (stim_q[k]) send_instr(stim_q[k].instr, stim_q[k].lit, stim_q[k].want);
      settle();

      program_csrs(32'd0, 32'd0);
      run_random(60);
      settle();
      run_random(75);
      settle();

      send_idle_pct = 87;
      recv_idle_pct = 20;
      program_csrs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(135);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_csrs($urandom, $urandom);
      run_random(135);
      settle();

      // halt on a nop, then requests that must be ignored
      program_csrs($urandom, core_pc + 32'd4);
      send_instr(enc_r(RF_ZERO, RF_ZERO, RF_ZERO, FN_NOP), 1'b0, '0);
      send_instr(enc_r(RF_RA, RF_ZERO, RF_ZERO, FN_JR), 1'b0, '0);
      repeat (6) send_instr(rand_instr(), 1'b0, '0);
      settle();

      if (pending_rsp.size() != 0)
         note_mismatch("responses never returned", pending_rsp.size(), 32'd0);
      $display("run: %0d requests (%0d directed), %0d responses; nop %0d R %0d I %0d J %0d unsup %0d",
               n_req, n_directed, n_rsp, class_seen[0], class_seen[1], class_seen[2],
               class_seen[3], class_seen[4]);
      $display("csr: reset, all-zero, all-ones and random pairs; halt reached, 7 requests ignored");
      if (mismatches == 0) begin
         $display("mips_subset_single_cycle_core_unit verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("mips_subset_single_cycle_core_unit verification failed");
      end
      $finish;
   end

endmodule
